### sv/pdvr_pkg.sv
`timescale 1ns / 1ps
// pdvr_pkg: widths, shift amounts, saturation limits and stage enable types
// shared by the pose delta velocity recovery block; no dependencies
package pdvr_pkg;

  localparam int POS_W   = 32;
  localparam int QUAT_W  = 64;
  localparam int COMP_W  = 16;
  localparam int PROD_W  = 2 * COMP_W;
  localparam int SUM_W   = PROD_W + 3;
  localparam int MAG_W   = 33;
  localparam int K_W     = 32;
  localparam int VEL_W   = 32;
  localparam int MUL_W   = 64;

  localparam int LIN_SHIFT = 16;
  localparam int ANG_SHIFT = 27;

  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pdvr_front_en_t;

  typedef struct packed {
    logic mul;
    logic fin;
  } pdvr_back_en_t;

endpackage

### sv/pdvr_quat.sv
`timescale 1ns / 1ps
// pdvr_quat: three-stage relative rotation path (component products, sums,
// shortest-arc sign and magnitude); depends on pdvr_pkg
module pdvr_quat import pdvr_pkg::*; (
  input  logic                 clk,
  input  pdvr_front_en_t       en,
  input  logic [QUAT_W-1:0]    orient_now,
  input  logic [QUAT_W-1:0]    orient_before,
  output logic [MAG_W-1:0]     mag_o [3],
  output logic                 neg_o [3]
);

  logic signed [COMP_W-1:0] a [4];
  logic signed [COMP_W-1:0] b [4];
  logic signed [PROD_W-1:0] prod_r [4][4];
  logic signed [SUM_W-1:0]  sum_r [4];
  logic signed [SUM_W-1:0]  sum_nxt [4];
  logic signed [SUM_W-1:0]  p [4][4];
  logic [MAG_W-1:0]         mag_r [3];
  logic                     neg_r [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = orient_now[QUAT_W-1-COMP_W*i -: COMP_W];
      b[i] = orient_before[QUAT_W-1-COMP_W*i -: COMP_W];
    end
  end

  // stage 1: all sixteen component products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i][j] <= a[i] * b[j];
        end
      end
    end
  end

  // stage 2: now times conjugate(before)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p[i][j] = SUM_W'(prod_r[i][j]);
      end
    end
    sum_nxt[0] =  p[0][0] + p[1][1] + p[2][2] + p[3][3];
    sum_nxt[1] = -p[0][1] + p[1][0] - p[2][3] + p[3][2];
    sum_nxt[2] = -p[0][2] + p[1][3] + p[2][0] - p[3][1];
    sum_nxt[3] = -p[0][3] - p[1][2] + p[2][1] + p[3][0];
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sum_r <= sum_nxt;
    end
  end

  // stage 3: sign folds in the shortest-arc flip
  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= sum_r[0][SUM_W-1] ^ sum_r[i+1][SUM_W-1];
        mag_r[i] <= sum_r[i+1][SUM_W-1] ? MAG_W'(-sum_r[i+1]) : MAG_W'(sum_r[i+1]);
      end
    end
  end

  assign mag_o = mag_r;
  assign neg_o = neg_r;

endmodule

### sv/pdvr_scale.sv
`timescale 1ns / 1ps
// pdvr_scale: one velocity lane, magnitude times inverse substep, then
// round half away from zero, saturate and restore sign; depends on pdvr_pkg
module pdvr_scale import pdvr_pkg::*; #(
  parameter int SHIFT = LIN_SHIFT
) (
  input  logic                 clk,
  input  pdvr_back_en_t        en,
  input  logic [MAG_W-1:0]     mag_i,
  input  logic                 neg_i,
  input  logic [K_W-1:0]       k_i,
  output logic [VEL_W-1:0]     vel_o
);

  localparam int Q_W = MUL_W + 1 - SHIFT;
  localparam logic [MUL_W:0] HALF = (MUL_W+1)'(1) << (SHIFT - 1);

  logic [MUL_W-1:0] prod_r;
  logic             neg_r;
  logic [VEL_W-1:0] vel_r;
  logic [MUL_W:0]   rnd;
  logic [Q_W-1:0]   q;
  logic             ovf;
  logic [VEL_W-1:0] vel_nxt;

  // magnitude never exceeds 2^32, so the top bit alone means low bits are zero
  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= mag_i[MAG_W-1] ? {k_i, {(MUL_W-K_W){1'b0}}}
                               : MUL_W'(mag_i[MAG_W-2:0]) * MUL_W'(k_i);
      neg_r  <= neg_i;
    end
  end

  always_comb begin
    rnd = {1'b0, prod_r} + HALF;
    q   = rnd[MUL_W:SHIFT];
    ovf = |q[Q_W-1:VEL_W-1];
    if (neg_r) begin
      vel_nxt = ovf ? VEL_MIN : -q[VEL_W-1:0];
    end else begin
      vel_nxt = ovf ? VEL_MAX : q[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.fin) begin
      vel_r <= vel_nxt;
    end
  end

  assign vel_o = vel_r;

endmodule

### sv/pose_delta_velocity_recovery.sv
`timescale 1ns / 1ps
// pose_delta_velocity_recovery: top level, stage control, position path and
// config register; depends on pdvr_pkg, pdvr_quat and pdvr_scale
//
// Recovers a rigid body's linear and angular velocity from its current and
// previous pose. One request is accepted per cycle unless the output stalls;
// each result passes through five register stages: component products
// and position difference, quaternion sums, sign and magnitude, the 33x32
// multiply by the inverse substep, and rounding with saturation. Each stage
// holds its own valid bit and advances when the stage after it is empty or
// moving, so a stalled output only backs up as far as needed. The inverse
// substep register is written through the cfg port, which is always ready,
// and should only change while no request is in flight; a value of zero gives
// zero velocities with result_valid low.
module pose_delta_velocity_recovery import pdvr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [K_W-1:0]          cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic signed [POS_W-1:0] in_prev_pos_x,
  input  logic signed [POS_W-1:0] in_prev_pos_y,
  input  logic signed [POS_W-1:0] in_prev_pos_z,
  input  logic [QUAT_W-1:0]       in_orient_now,
  input  logic [QUAT_W-1:0]       in_orient_before,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VEL_W-1:0] out_lin_vel_x,
  output logic signed [VEL_W-1:0] out_lin_vel_y,
  output logic signed [VEL_W-1:0] out_lin_vel_z,
  output logic signed [VEL_W-1:0] out_ang_vel_x,
  output logic signed [VEL_W-1:0] out_ang_vel_y,
  output logic signed [VEL_W-1:0] out_ang_vel_z,
  output logic                    out_result_valid
);

  logic [K_W-1:0]   inv_substep_r;
  logic [4:0]       v_r;
  logic [4:0]       v_nxt;
  logic [4:0]       en;
  pdvr_front_en_t   front_en;
  pdvr_back_en_t    back_en;
  logic             rv_r;

  logic signed [POS_W-1:0] cur [3];
  logic signed [POS_W-1:0] prv [3];
  logic signed [MAG_W-1:0] diff [3];
  logic [MAG_W-1:0]        lin_mag1_r [3];
  logic [MAG_W-1:0]        lin_mag2_r [3];
  logic [MAG_W-1:0]        lin_mag3_r [3];
  logic                    lin_neg1_r [3];
  logic                    lin_neg2_r [3];
  logic                    lin_neg3_r [3];
  logic [MAG_W-1:0]        ang_mag [3];
  logic                    ang_neg [3];
  logic [VEL_W-1:0]        lin_vel [3];
  logic [VEL_W-1:0]        ang_vel [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_substep_r <= '0;
    end else if (cfg_valid) begin
      inv_substep_r <= cfg_data;
    end
  end

  // stage k moves when empty or when stage k+1 moves
  always_comb begin
    en[4] = !v_r[4] || out_ready;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < 5; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[4];

  assign front_en.s1 = en[0];
  assign front_en.s2 = en[1];
  assign front_en.s3 = en[2];
  assign back_en.mul = en[3];
  assign back_en.fin = en[4];

  // position difference, carried alongside the quaternion stages
  always_comb begin
    cur[0] = in_pos_x;
    cur[1] = in_pos_y;
    cur[2] = in_pos_z;
    prv[0] = in_prev_pos_x;
    prv[1] = in_prev_pos_y;
    prv[2] = in_prev_pos_z;
    for (int i = 0; i < 3; i++) begin
      diff[i] = MAG_W'(cur[i]) - MAG_W'(prv[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (en[0]) begin
        lin_neg1_r[i] <= diff[i][MAG_W-1];
        lin_mag1_r[i] <= diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
      end
      if (en[1]) begin
        lin_neg2_r[i] <= lin_neg1_r[i];
        lin_mag2_r[i] <= lin_mag1_r[i];
      end
      if (en[2]) begin
        lin_neg3_r[i] <= lin_neg2_r[i];
        lin_mag3_r[i] <= lin_mag2_r[i];
      end
    end
  end

  pdvr_quat u_quat (
    .clk           (clk),
    .en            (front_en),
    .orient_now    (in_orient_now),
    .orient_before (in_orient_before),
    .mag_o         (ang_mag),
    .neg_o         (ang_neg)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pdvr_scale #(.SHIFT(LIN_SHIFT)) u_lin (
      .clk   (clk),
      .en    (back_en),
      .mag_i (lin_mag3_r[g]),
      .neg_i (lin_neg3_r[g]),
      .k_i   (inv_substep_r),
      .vel_o (lin_vel[g])
    );

    pdvr_scale #(.SHIFT(ANG_SHIFT)) u_ang (
      .clk   (clk),
      .en    (back_en),
      .mag_i (ang_mag[g]),
      .neg_i (ang_neg[g]),
      .k_i   (inv_substep_r),
      .vel_o (ang_vel[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rv_r <= |inv_substep_r;
    end
  end

  assign out_lin_vel_x    = lin_vel[0];
  assign out_lin_vel_y    = lin_vel[1];
  assign out_lin_vel_z    = lin_vel[2];
  assign out_ang_vel_x    = ang_vel[0];
  assign out_ang_vel_y    = ang_vel[1];
  assign out_ang_vel_z    = ang_vel[2];
  assign out_result_valid = rv_r;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking regression for pose_delta_velocity_recovery
// depends on pdvr_pkg and the block; a scoreboard class predicts each result
module testbench;
  import pdvr_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 205;
  localparam int N_DIRECTED  = 8;
  localparam int N_PHASES    = 9;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][POS_W-1:0] prev;
    logic [QUAT_W-1:0]     orient_now;
    logic [QUAT_W-1:0]     orient_before;
  } body_pose_t;

  typedef struct packed {
    logic [2:0][VEL_W-1:0] lin;
    logic [2:0][VEL_W-1:0] ang;
    logic                  flag;
  } body_vel_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  class velocity_scoreboard;
    body_vel_t      expected_vel[$];
    logic [K_W-1:0] inv_substep;
    int             mismatches;
    int             requests;
    int             checked;
    int             printed;

    function new();
      inv_substep = '0;
      mismatches = 0;
      requests = 0;
      checked = 0;
      printed = 0;
    endfunction

    function void set_inverse_substep(logic [K_W-1:0] value);
      inv_substep = value;
    endfunction

    function int pending();
      return expected_vel.size();
    endfunction

    function logic [VEL_W-1:0] scale_round_sat(logic signed [63:0] v, logic [K_W-1:0] k,
                                               int sh);
      logic [95:0] mag;
      logic [95:0] prod;
      logic [95:0] q;
      mag = (v < 0) ? -v : v;
      prod = mag * {64'b0, k};
      q = (prod + (96'd1 << (sh - 1))) >> sh;
      if (v < 0) begin
        return (q >= 96'h8000_0000) ? VEL_MIN : VEL_W'(96'd0 - q);
      end
      return (q > 96'h7FFF_FFFF) ? VEL_MAX : VEL_W'(q);
    endfunction

    function body_vel_t recover_velocity(body_pose_t p);
      body_vel_t         r;
      logic signed [63:0] a[4];
      logic signed [63:0] b[4];
      logic signed [63:0] dv[3];
      logic signed [63:0] dw;
      logic signed [63:0] d;
      r = '0;
      if (inv_substep == '0) begin
        return r;
      end
      for (int i = 0; i < 3; i++) begin
        d = $signed(p.pos[i]) - $signed(p.prev[i]);
        r.lin[i] = scale_round_sat(d, inv_substep, LIN_SHIFT);
      end
      for (int i = 0; i < 4; i++) begin
        a[i] = $signed(p.orient_now[QUAT_W-1-COMP_W*i -: COMP_W]);
        b[i] = $signed(p.orient_before[QUAT_W-1-COMP_W*i -: COMP_W]);
      end
      dw    =  a[0] * b[0] + a[1] * b[1] + a[2] * b[2] + a[3] * b[3];
      dv[0] = -a[0] * b[1] + a[1] * b[0] - a[2] * b[3] + a[3] * b[2];
      dv[1] = -a[0] * b[2] + a[1] * b[3] + a[2] * b[0] - a[3] * b[1];
      dv[2] = -a[0] * b[3] - a[1] * b[2] + a[2] * b[1] + a[3] * b[0];
      // shortest arc
      for (int i = 0; i < 3; i++) begin
        d = (dw < 0) ? -dv[i] : dv[i];
        r.ang[i] = scale_round_sat(d, inv_substep, ANG_SHIFT);
      end
      r.flag = 1'b1;
      return r;
    endfunction

    function void note_request(body_pose_t p);
      expected_vel.push_back(recover_velocity(p));
      requests++;
    endfunction

    task report_mismatch(string msg);
      if (printed < 40) begin
        $display("mismatch at %0t: %s", $realtime, msg);
        printed++;
      end
      mismatches++;
    endtask

    task check_result(body_vel_t got);
      body_vel_t want;
      if (expected_vel.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", got));
        return;
      end
      want = expected_vel.pop_front();
      checked++;
      for (int i = 0; i < 3; i++) begin
        if (got.lin[i] !== want.lin[i]) begin
          report_mismatch($sformatf("result %0d lin_vel[%0d] got %h want %h",
                                    checked, i, got.lin[i], want.lin[i]));
        end
        if (got.ang[i] !== want.ang[i]) begin
          report_mismatch($sformatf("result %0d ang_vel[%0d] got %h want %h",
                                    checked, i, got.ang[i], want.ang[i]));
        end
      end
      if (got.flag !== want.flag) begin
        report_mismatch($sformatf("result %0d result_valid got %b want %b",
                                  checked, got.flag, want.flag));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [K_W-1:0]          cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic signed [POS_W-1:0] in_pos_z;
  logic signed [POS_W-1:0] in_prev_pos_x;
  logic signed [POS_W-1:0] in_prev_pos_y;
  logic signed [POS_W-1:0] in_prev_pos_z;
  logic [QUAT_W-1:0]       in_orient_now;
  logic [QUAT_W-1:0]       in_orient_before;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VEL_W-1:0] out_lin_vel_x;
  logic signed [VEL_W-1:0] out_lin_vel_y;
  logic signed [VEL_W-1:0] out_lin_vel_z;
  logic signed [VEL_W-1:0] out_ang_vel_x;
  logic signed [VEL_W-1:0] out_ang_vel_y;
  logic signed [VEL_W-1:0] out_ang_vel_z;
  logic                    out_result_valid;

  velocity_scoreboard sb = new();
  body_pose_t         port_pose;
  body_vel_t          port_vel;
  int                 hold_requests = 0;
  int                 settings_used = 0;

  pose_delta_velocity_recovery uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_prev_pos_x    (in_prev_pos_x),
    .in_prev_pos_y    (in_prev_pos_y),
    .in_prev_pos_z    (in_prev_pos_z),
    .in_orient_now    (in_orient_now),
    .in_orient_before (in_orient_before),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_lin_vel_x    (out_lin_vel_x),
    .out_lin_vel_y    (out_lin_vel_y),
    .out_lin_vel_z    (out_lin_vel_z),
    .out_ang_vel_x    (out_ang_vel_x),
    .out_ang_vel_y    (out_ang_vel_y),
    .out_ang_vel_z    (out_ang_vel_z),
    .out_result_valid (out_result_valid)
  );

  assign port_pose = {in_pos_z, in_pos_y, in_pos_x, in_prev_pos_z, in_prev_pos_y,
                      in_prev_pos_x, in_orient_now, in_orient_before};
  assign port_vel  = {out_lin_vel_z, out_lin_vel_y, out_lin_vel_x, out_ang_vel_z,
                      out_ang_vel_y, out_ang_vel_x, out_result_valid};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_inverse_substep(cfg_data);
      end
      if (in_valid && in_ready) begin
        sb.note_request(port_pose);
      end
      if (out_valid && out_ready) begin
        sb.check_result(port_vel);
      end
    end
  end

  // receiver stall patterns, plus a long hold-off on request
  initial begin
    rx_pattern_t pattern;
    int          pattern_left;
    int          hold_left;
    int          hold_seen;
    int          cyc;
    pattern = RX_OPEN;
    pattern_left = 0;
    hold_left = 0;
    hold_seen = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = rx_pattern_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (pattern)
          RX_OPEN:  out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 9) < 7);
          RX_HEAVY: out_ready <= ($urandom_range(0, 9) < 3);
          default:  out_ready <= ((cyc % 5) != 0);
        endcase
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("pose_delta_velocity_recovery regression: fail");
    $finish;
  end

  function automatic logic [COMP_W-1:0] near_unit_comp();
    return COMP_W'($urandom_range(0, 32767)) - COMP_W'(16384);
  endfunction

  function automatic logic [QUAT_W-1:0] near_unit_quat();
    return {near_unit_comp(), near_unit_comp(), near_unit_comp(), near_unit_comp()};
  endfunction

  function automatic body_pose_t random_pose();
    body_pose_t p;
    int         kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = $urandom;
      case (kind)
        0:       p.prev[i] = $urandom;
        1:       p.prev[i] = p.pos[i] + POS_W'($urandom_range(0, 16)) - POS_W'(8);
        default: p.prev[i] = p.pos[i] + POS_W'($urandom_range(0, 131072)) - POS_W'(65536);
      endcase
    end
    if (kind == 0 || kind == 3) begin
      p.orient_now = {$urandom, $urandom};
      p.orient_before = {$urandom, $urandom};
    end else begin
      p.orient_now = near_unit_quat();
      p.orient_before = near_unit_quat();
    end
    return p;
  endfunction

  function automatic body_pose_t directed_pose(int n);
    body_pose_t p;
    p = '0;
    case (n)
      0: begin
        p.orient_now = 64'h4000_0000_0000_0000;
        p.orient_before = 64'h4000_0000_0000_0000;
      end
      1: begin
        p.pos[0] = 32'h7FFF_FFFF;
        p.prev[0] = 32'h8000_0000;
        p.pos[1] = 32'h8000_0000;
        p.prev[1] = 32'h7FFF_FFFF;
        p.pos[2] = 32'd1;
        p.orient_now = 64'h4000_0000_0000_0000;
        p.orient_before = 64'hC000_0000_0000_0000;
      end
      2: begin
        p.pos[0] = 32'd1;
        p.prev[1] = 32'd1;
        p.pos[2] = 32'd3;
        p.orient_now = 64'h7FFF_7FFF_7FFF_7FFF;
        p.orient_before = 64'h8000_8000_8000_8000;
      end
      3: begin
        // zero scalar part of the relative rotation
        p.pos[0] = 32'hFFFF_FFFF;
        p.prev[2] = 32'hFFFF_FFFF;
        p.orient_now = 64'h0000_4000_0000_0000;
        p.orient_before = 64'h4000_0000_0000_0000;
      end
      4: begin
        p.pos = {32'h0001_8000, 32'hFFFE_8000, 32'h0000_8000};
        p.orient_now = 64'hE000_2000_1000_F000;
        p.orient_before = 64'h4000_0000_0000_0000;
      end
      5: begin
        p.pos = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        p.orient_now = 64'hFFFF_FFFF_FFFF_FFFF;
        p.orient_before = 64'h0000_0000_0000_0000;
      end
      6: begin
        p.prev = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        p.orient_now = 64'h8000_8000_8000_8000;
        p.orient_before = 64'h8000_8000_8000_8000;
      end
      default: begin
        p.pos = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        p.prev = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        p.orient_now = 64'h8000_7FFF_8000_7FFF;
        p.orient_before = 64'h7FFF_8000_7FFF_8000;
      end
    endcase
    return p;
  endfunction

  task write_inverse_substep(logic [K_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // waits on the clock first so the monitor has noted the last request
  task wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task send_pose(body_pose_t p);
    in_valid <= 1'b1;
    in_pos_x <= p.pos[0];
    in_pos_y <= p.pos[1];
    in_pos_z <= p.pos[2];
    in_prev_pos_x <= p.prev[0];
    in_prev_pos_y <= p.prev[1];
    in_prev_pos_z <= p.prev[2];
    in_orient_now <= p.orient_now;
    in_orient_before <= p.orient_before;
    do @(posedge clk); while (!in_ready);
  endtask

  task send_directed();
    for (int n = 0; n < N_DIRECTED; n++) begin
      send_pose(directed_pose(n));
    end
    in_valid <= 1'b0;
  endtask

  task send_random_bursts(int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    gap = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      for (int j = 0; j < burst && sent < count; j++) begin
        send_pose(random_pose());
        sent++;
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (gap == 0) begin
      in_valid <= 1'b0;
    end
  endtask

  initial begin
    logic [K_W-1:0] phase_k[N_PHASES];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_prev_pos_x = '0;
    in_prev_pos_y = '0;
    in_prev_pos_z = '0;
    in_orient_now = '0;
    in_orient_before = '0;
    out_ready = 1'b0;
    phase_k = '{32'h0001_0000, 32'h003C_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h00F0_0000,
                $urandom, 32'h0000_0000, $urandom_range(1, 32'h00FF_FFFF), 32'h8000_0000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the register is zero, so this set is the invalid substep
    send_directed();
    wait_drained();
    write_inverse_substep(32'hFFFF_FFFF);
    send_directed();
    wait_drained();
    // half an lsb per unit of difference gives rounding ties
    write_inverse_substep(32'h0000_8000);
    send_directed();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      write_inverse_substep(phase_k[ph]);
      if (ph == 2) begin
        hold_requests++;
      end
      send_random_bursts(PHASE_ITEMS);
    end

    wait_drained();
    repeat (12) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d inverse substep settings",
             sb.requests, sb.checked, settings_used);
    $display("included invalid substep, saturation, rounding ties, shortest arc and stalls");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("pose_delta_velocity_recovery regression: pass");
    end else begin
      $display("pose_delta_velocity_recovery regression: fail");
    end
    $finish;
  end

endmodule

### files.f
sv/pdvr_pkg.sv
sv/pdvr_quat.sv
sv/pdvr_scale.sv
sv/pose_delta_velocity_recovery.sv
tb/testbench.sv
